### rtl/core/mouse_packet_event_mapper_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mouse packet event mapper
// Concurrent checks that compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef MOUSE_PACKET_EVENT_MAPPER_ASSERT_SVH
`define MOUSE_PACKET_EVENT_MAPPER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MPEM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define MPEM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MPEM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define MPEM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### rtl/core/mpem_pkg.sv
// ----------------------------------------------------------------------------
// mpem_pkg
// Types and constants shared by the mouse packet event mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mpem_pkg;

  // Event kinds.
  localparam logic [1:0] KIND_KEY = 2'd1;
  localparam logic [1:0] KIND_REL = 2'd2;

  // Event codes.
  localparam logic [8:0] CODE_X      = 9'd0;
  localparam logic [8:0] CODE_Y      = 9'd1;
  localparam logic [8:0] CODE_LEFT   = 9'd272;
  localparam logic [8:0] CODE_RIGHT  = 9'd273;
  localparam logic [8:0] CODE_MIDDLE = 9'd274;

  // Most events one packet can cause; larger limits act as this.
  localparam logic [2:0] MOST_EVENTS = 3'd5;
  localparam logic [2:0] LIMIT_RESET = 3'd5;

  // Event slots, in the order they are emitted.
  localparam int unsigned NUM_SLOTS = 5;
  localparam int unsigned SLOT_X    = 0;
  localparam int unsigned SLOT_Y    = 1;
  localparam int unsigned SLOT_L    = 2;
  localparam int unsigned SLOT_R    = 3;
  localparam int unsigned SLOT_M    = 4;

  // Status byte bit positions.
  localparam int unsigned BIT_X_SIGN = 4;
  localparam int unsigned BIT_Y_SIGN = 5;

  // A decoded packet waiting to be emitted.
  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;   // events still to emit
    logic [8:0]           dx;
    logic [8:0]           dy;
    logic [2:0]           btn;    // button state of this packet
    logic [63:0]          stamp;
  } mpem_pend_t;

  // Emitter feedback to the decode stage.
  typedef struct packed {
    logic                 take;   // an event leaves the pending register
    logic [NUM_SLOTS-1:0] rem;    // mask left after that event
  } mpem_pop_t;

endpackage

`default_nettype wire

### rtl/core/mpem_pkt_if.sv
// ----------------------------------------------------------------------------
// mpem_pkt_if
// Valid/ready channel carrying one three-byte mouse packet and its timestamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mpem_pkt_if;
  logic        valid;
  logic        ready;
  logic [7:0]  status_byte;
  logic [7:0]  x_byte;
  logic [7:0]  y_byte;
  logic [63:0] stamp_in;

  modport source (output valid, status_byte, x_byte, y_byte, stamp_in, input ready);
  modport sink   (input valid, status_byte, x_byte, y_byte, stamp_in, output ready);
endinterface

`default_nettype wire

### rtl/core/mpem_evt_if.sv
// ----------------------------------------------------------------------------
// mpem_evt_if
// Valid/ready channel carrying one input event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mpem_evt_if;
  logic               valid;
  logic               ready;
  logic [63:0]        event_time;
  logic [1:0]         event_kind;
  logic [8:0]         event_code;
  logic signed [8:0]  event_value;
  logic               last_event;

  modport source (output valid, event_time, event_kind, event_code, event_value,
                  last_event, input ready);
  modport sink   (input valid, event_time, event_kind, event_code, event_value,
                  last_event, output ready);
endinterface

`default_nettype wire

### rtl/core/mpem_decode.sv
// ----------------------------------------------------------------------------
// mpem_decode
// Decodes a packet into a mask of events, capped by the limit register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpem_decode (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_wdata_i,
  mpem_pkt_if.sink                 pkt_i,
  input  wire mpem_pkg::mpem_pop_t pop_i,
  output mpem_pkg::mpem_pend_t     pend_o
);

  logic [2:0]                     max_events_q;
  logic [2:0]                     prev_btn_q;
  mpem_pkg::mpem_pend_t           pend_q;
  logic                           accept;
  logic [8:0]                     dx;
  logic [8:0]                     dy;
  logic [2:0]                     btn;
  logic [2:0]                     limit;
  logic [mpem_pkg::NUM_SLOTS-1:0] cand;
  logic [mpem_pkg::NUM_SLOTS-1:0] capped;
  logic [2:0]                     cnt;

  assign dx  = {pkt_i.status_byte[mpem_pkg::BIT_X_SIGN], pkt_i.x_byte};
  assign dy  = {pkt_i.status_byte[mpem_pkg::BIT_Y_SIGN], pkt_i.y_byte};
  assign btn = pkt_i.status_byte[2:0];

  assign limit = (max_events_q > mpem_pkg::MOST_EVENTS) ? mpem_pkg::MOST_EVENTS
                                                        : max_events_q;

  always_comb begin
    cand                 = '0;
    cand[mpem_pkg::SLOT_X] = (dx != 9'd0);
    cand[mpem_pkg::SLOT_Y] = (dy != 9'd0);
    cand[mpem_pkg::SLOT_L] = btn[0] ^ prev_btn_q[0];
    cand[mpem_pkg::SLOT_R] = btn[1] ^ prev_btn_q[1];
    cand[mpem_pkg::SLOT_M] = btn[2] ^ prev_btn_q[2];
  end

  // Keep only the first events, up to the limit; the rest are dropped.
  always_comb begin
    capped = '0;
    cnt    = 3'd0;
    for (int i = 0; i < mpem_pkg::NUM_SLOTS; i++) begin
      if (cand[i] && (cnt < limit)) begin
        capped[i] = 1'b1;
        cnt       = cnt + 3'd1;
      end
    end
  end

  // A new packet may enter once the pending one has nothing left after this cycle.
  assign pkt_i.ready = (pend_q.mask == '0) || (pop_i.take && (pop_i.rem == '0));
  assign accept      = pkt_i.valid && pkt_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_events_q <= mpem_pkg::LIMIT_RESET;
      prev_btn_q   <= 3'd0;
      pend_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        max_events_q <= cfg_wdata_i;
      end
      if (accept) begin
        prev_btn_q   <= btn;
        pend_q.mask  <= capped;
        pend_q.dx    <= dx;
        pend_q.dy    <= dy;
        pend_q.btn   <= btn;
        pend_q.stamp <= pkt_i.stamp_in;
      end else if (pop_i.take) begin
        pend_q.mask <= pop_i.rem;
      end
    end
  end

  assign pend_o = pend_q;

endmodule

`default_nettype wire

### rtl/core/mpem_emit.sv
// ----------------------------------------------------------------------------
// mpem_emit
// Picks the next pending event and holds it in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpem_emit (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mpem_pkg::mpem_pend_t pend_i,
  output mpem_pkg::mpem_pop_t       pop_o,
  mpem_evt_if.source                evt_o
);

  logic                           valid_q;
  logic [63:0]                    time_q;
  logic [1:0]                     kind_q;
  logic [8:0]                     code_q;
  logic signed [8:0]              value_q;
  logic                           last_q;
  logic                           load;
  logic                           take;
  logic [mpem_pkg::NUM_SLOTS-1:0] sel;
  logic [mpem_pkg::NUM_SLOTS-1:0] rem;
  logic [1:0]                     kind_d;
  logic [8:0]                     code_d;
  logic signed [8:0]              value_d;

  // Lowest set bit of the pending mask is the next event in order.
  assign sel  = pend_i.mask & (~pend_i.mask + 5'd1);
  assign rem  = pend_i.mask & ~sel;
  assign load = !valid_q || evt_o.ready;
  assign take = (pend_i.mask != '0) && load;

  always_comb begin
    kind_d  = mpem_pkg::KIND_KEY;
    code_d  = mpem_pkg::CODE_MIDDLE;
    value_d = signed'({8'd0, pend_i.btn[2]});
    if (sel[mpem_pkg::SLOT_X]) begin
      kind_d  = mpem_pkg::KIND_REL;
      code_d  = mpem_pkg::CODE_X;
      value_d = signed'(pend_i.dx);
    end else if (sel[mpem_pkg::SLOT_Y]) begin
      kind_d  = mpem_pkg::KIND_REL;
      code_d  = mpem_pkg::CODE_Y;
      value_d = signed'(pend_i.dy);
    end else if (sel[mpem_pkg::SLOT_L]) begin
      code_d  = mpem_pkg::CODE_LEFT;
      value_d = signed'({8'd0, pend_i.btn[0]});
    end else if (sel[mpem_pkg::SLOT_R]) begin
      code_d  = mpem_pkg::CODE_RIGHT;
      value_d = signed'({8'd0, pend_i.btn[1]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= (pend_i.mask != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      time_q  <= pend_i.stamp;
      kind_q  <= kind_d;
      code_q  <= code_d;
      value_q <= value_d;
      last_q  <= (rem == '0);
    end
  end

  assign pop_o             = '{take: take, rem: rem};
  assign evt_o.valid       = valid_q;
  assign evt_o.event_time  = time_q;
  assign evt_o.event_kind  = kind_q;
  assign evt_o.event_code  = code_q;
  assign evt_o.event_value = value_q;
  assign evt_o.last_event  = last_q;

endmodule

`default_nettype wire

### rtl/core/mouse_packet_event_mapper.sv
// ----------------------------------------------------------------------------
// mouse_packet_event_mapper
// Turns three-byte PS/2 mouse packets into relative-motion and key events.
// ----------------------------------------------------------------------------
// Usage: a packet (status, X and Y bytes plus a 64-bit timestamp) arrives on
// the pkt_i valid/ready channel. Each packet yields zero to five events on
// the evt_o channel, in the order X motion, Y motion, left, right, middle,
// each only when nonzero or changed. The last event of a packet carries
// last_event. The max_events register (cfg_we_i / cfg_wdata_i) caps the
// count; values above five act as five and later events are dropped.
// The first event of a packet passes the pending register and then the
// output register before it is valid. Events leave at one event per cycle
// while the receiver takes them; the single output register sets that
// rate. The next packet is taken in the cycle its predecessor hands its
// last event to the output register, so events stream without gaps.
// Reset clears the pending register and the output valid bit, sets the limit
// to five and marks all buttons released. When the receiver stalls, the
// current event holds in the output register and pkt_i.ready drops once
// the pending packet still has events to send.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "mouse_packet_event_mapper_assert.svh"

module mouse_packet_event_mapper (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_wdata_i,
  mpem_pkt_if.sink        pkt_i,
  mpem_evt_if.source      evt_o
);

  // Decoded packet in flight and the emitter's feedback on it.
  mpem_pkg::mpem_pend_t pend;
  mpem_pkg::mpem_pop_t  pop;

  // Decode stage: sign-extends motion, compares buttons with the previous
  // packet and caps the resulting event mask.
  mpem_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pkt_i       (pkt_i),
    .pop_i       (pop),
    .pend_o      (pend)
  );

  // Emit stage: one event per cycle into the output register while the receiver takes them.
  mpem_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pend_i (pend),
    .pop_o  (pop),
    .evt_o  (evt_o)
  );

  // Each emitted event removes exactly one entry from the pending mask.
  `MPEM_ASSERT_NXT(a_pop_one, clk_i, rst_ni, pop.take && !(pkt_i.valid && pkt_i.ready), $countones(pend.mask) == $countones($past(pend.mask)) - 1, "pop did not remove exactly one event")

  // Motion events carry only axis codes.
  `MPEM_ASSERT_IMP(a_rel_code, clk_i, rst_ni, evt_o.valid && (evt_o.event_kind == mpem_pkg::KIND_REL), (evt_o.event_code == mpem_pkg::CODE_X) || (evt_o.event_code == mpem_pkg::CODE_Y), "motion event with a button code")

  // Key events report pressed or released only.
  `MPEM_ASSERT_IMP(a_key_value, clk_i, rst_ni, evt_o.valid && (evt_o.event_kind == mpem_pkg::KIND_KEY), (evt_o.event_value == 9'sd0) || (evt_o.event_value == 9'sd1), "key event value out of range")

endmodule

`default_nettype wire

### dv/tb_mouse_packet_event_mapper.sv
// ----------------------------------------------------------------------------
// tb_mouse_packet_event_mapper
// Self-checking bench: a table of directed packets, then random packets under
// three idling regimes, with every event checked against the model or its typed row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mouse_packet_event_mapper;

  // One mouse packet as offered on the packet channel.
  typedef struct packed {
    logic [7:0]  status;
    logic [7:0]  xb;
    logic [7:0]  yb;
    logic [63:0] stamp;
  } packet_t;

  // One event as it should leave the event channel.
  typedef struct packed {
    logic [63:0]       stamp;
    logic [1:0]        kind;
    logic [8:0]        code;
    logic signed [8:0] value;
    logic              last;
  } mouse_event_t;

  // A directed row. When typed is set, the expected outcome is written into
  // the row itself: either no event at all, or exactly the one event given.
  // Rows without typed expectations are checked against the event model.
  typedef struct packed {
    logic [2:0]   limit;
    packet_t      pkt;
    logic         typed;
    logic         has_ev;
    mouse_event_t ev;
  } directed_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i;
  logic [2:0] cfg_wdata_i;

  mpem_pkt_if pkt_if ();
  mpem_evt_if evt_if ();

  mouse_packet_event_mapper DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pkt_i      (pkt_if),
    .evt_o      (evt_if)
  );

  // Model state: the limit register and the buttons of the previous packet.
  logic [2:0] model_limit = mpem_pkg::LIMIT_RESET;
  logic [2:0] model_buttons = 3'b000;

  // Events predicted for accepted packets and not yet seen at the output.
  mouse_event_t pending_events[$];

  int unsigned fail_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request = 1'b0;

  // The directed part. The stamp of a typed event is taken from its packet.
  directed_row_t directed_rows [20] = '{
    // Only the always-one bit set: nothing moved, nothing changed.
    '{3'd5, '{8'h08, 8'h00, 8'h00, 64'd0}, 1'b1, 1'b0, '0},
    // Left button pressed right after reset.
    '{3'd5, '{8'h01, 8'h00, 8'h00, 64'd1}, 1'b1, 1'b1,
      '{64'd0, mpem_pkg::KIND_KEY, mpem_pkg::CODE_LEFT, 9'sd1, 1'b1}},
    // Most negative X with the largest timestamp.
    '{3'd5, '{8'h11, 8'h00, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, 1'b1,
      '{64'd0, mpem_pkg::KIND_REL, mpem_pkg::CODE_X, 9'h100, 1'b1}},
    // Y of minus one.
    '{3'd5, '{8'h21, 8'h00, 8'hFF, 64'h8000_0000_0000_0000}, 1'b1, 1'b1,
      '{64'd0, mpem_pkg::KIND_REL, mpem_pkg::CODE_Y, 9'h1FF, 1'b1}},
    // Most positive X.
    '{3'd5, '{8'h01, 8'hFF, 8'h00, 64'd3}, 1'b1, 1'b1,
      '{64'd0, mpem_pkg::KIND_REL, mpem_pkg::CODE_X, 9'sd255, 1'b1}},
    // Overflow bits and the always-one bit alone are ignored.
    '{3'd5, '{8'hC9, 8'h00, 8'h00, 64'd4}, 1'b1, 1'b0, '0},
    // All five events in one packet.
    '{3'd5, '{8'h36, 8'h80, 8'h7F, 64'h0123_4567_89AB_CDEF}, 1'b0, 1'b0, '0},
    '{3'd5, '{8'h07, 8'h01, 8'h01, 64'h5555_AAAA_5555_AAAA}, 1'b0, 1'b0, '0},
    // Every button released at once.
    '{3'd5, '{8'h00, 8'h00, 8'h00, 64'hAAAA_5555_AAAA_5555}, 1'b0, 1'b0, '0},
    // A limit of zero drops everything.
    '{3'd0, '{8'h00, 8'h05, 8'h00, 64'd9}, 1'b1, 1'b0, '0},
    // The dropped presses are still remembered as the button state.
    '{3'd0, '{8'h07, 8'h00, 8'h00, 64'd10}, 1'b1, 1'b0, '0},
    '{3'd5, '{8'h07, 8'h00, 8'h00, 64'd11}, 1'b1, 1'b0, '0},
    // A limit of one keeps only X; the button releases are discarded.
    '{3'd1, '{8'h30, 8'h03, 8'h04, 64'd12}, 1'b1, 1'b1,
      '{64'd0, mpem_pkg::KIND_REL, mpem_pkg::CODE_X, 9'h103, 1'b1}},
    '{3'd2, '{8'h07, 8'h00, 8'h09, 64'd13}, 1'b0, 1'b0, '0},
    // Limits of six and seven behave as five.
    '{3'd6, '{8'h30, 8'h55, 8'hAA, 64'hFFFF_0000_FFFF_0000}, 1'b0, 1'b0, '0},
    '{3'd7, '{8'h3F, 8'hFF, 8'hFF, 64'h0000_FFFF_0000_FFFF}, 1'b0, 1'b0, '0},
    '{3'd3, '{8'h02, 8'h01, 8'h01, 64'd16}, 1'b0, 1'b0, '0},
    '{3'd4, '{8'h05, 8'h00, 8'h00, 64'd17}, 1'b0, 1'b0, '0},
    '{3'd5, '{8'h04, 8'h7F, 8'h80, 64'd18}, 1'b0, 1'b0, '0},
    '{3'd5, '{8'h10, 8'h00, 8'h00, 64'd19}, 1'b0, 1'b0, '0}
  };

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Works out the events one packet causes and advances the button memory.
  // Motion is nine bits wide: the byte below, the sign bit from the status.
  function automatic void predict_events(input packet_t p, output mouse_event_t evs[$]);
    logic [8:0]   dx;
    logic [8:0]   dy;
    logic [2:0]   btn;
    logic [2:0]   cap;
    logic [8:0]   btn_code [3];
    mouse_event_t ev;
    btn_code = '{mpem_pkg::CODE_LEFT, mpem_pkg::CODE_RIGHT, mpem_pkg::CODE_MIDDLE};
    dx  = {p.status[mpem_pkg::BIT_X_SIGN], p.xb};
    dy  = {p.status[mpem_pkg::BIT_Y_SIGN], p.yb};
    btn = p.status[2:0];
    cap = (model_limit > mpem_pkg::MOST_EVENTS) ? mpem_pkg::MOST_EVENTS : model_limit;
    evs.delete();
    ev = '0;
    ev.stamp = p.stamp;
    if (dx != 9'd0 && evs.size() < cap) begin
      ev.kind  = mpem_pkg::KIND_REL;
      ev.code  = mpem_pkg::CODE_X;
      ev.value = dx;
      evs.push_back(ev);
    end
    if (dy != 9'd0 && evs.size() < cap) begin
      ev.kind  = mpem_pkg::KIND_REL;
      ev.code  = mpem_pkg::CODE_Y;
      ev.value = dy;
      evs.push_back(ev);
    end
    for (int i = 0; i < 3 && evs.size() < cap; i++) begin
      if (btn[i] != model_buttons[i]) begin
        ev.kind  = mpem_pkg::KIND_KEY;
        ev.code  = btn_code[i];
        ev.value = {8'd0, btn[i]};
        evs.push_back(ev);
      end
    end
    if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
    // The button memory follows every packet, even when key events were cut.
    model_buttons = btn;
  endfunction

  // Random packet. Motion and button changes are often suppressed, so that
  // short packets, quiet packets and every mix in between are common.
  function automatic packet_t random_packet();
    packet_t p;
    p.status = 8'($urandom);
    p.xb     = 8'($urandom);
    p.yb     = 8'($urandom);
    p.stamp  = {$urandom, $urandom};
    if ($urandom_range(3) == 0) begin
      p.xb = 8'h00;
      p.status[mpem_pkg::BIT_X_SIGN] = 1'b0;
    end
    if ($urandom_range(3) == 0) begin
      p.yb = 8'h00;
      p.status[mpem_pkg::BIT_Y_SIGN] = 1'b0;
    end
    if ($urandom_range(3) == 0) p.status[2:0] = model_buttons;
    return p;
  endfunction

  // Offers one packet, waits for its transfer and books its events. Valid is
  // left high on return, so a following packet can go out back to back.
  task automatic send_packet(input packet_t p, input logic typed, input logic has_ev,
                             input mouse_event_t typed_ev);
    mouse_event_t evs[$];
    while ($urandom_range(99) < send_idle_pct) begin
      pkt_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pkt_if.valid       <= 1'b1;
    pkt_if.status_byte <= p.status;
    pkt_if.x_byte      <= p.xb;
    pkt_if.y_byte      <= p.yb;
    pkt_if.stamp_in    <= p.stamp;
    @(posedge clk_i);
    while (!pkt_if.ready) @(posedge clk_i);
    predict_events(p, evs);
    if (typed) begin
      evs.delete();
      if (has_ev) begin
        typed_ev.stamp = p.stamp;
        evs.push_back(typed_ev);
      end
    end
    foreach (evs[i]) pending_events.push_back(evs[i]);
  endtask

  // Writes the limit register once the block has drained. A packet that
  // causes no event may still sit in the pending register when the queue
  // runs empty, so the task keeps waiting after that before it writes.
  task automatic write_limit(input logic [2:0] value);
    pkt_if.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    model_limit = value;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Receiver. It stalls at random at the current rate; a hold request makes
  // it refuse every event for a long stretch so the block backs up.
  int unsigned hold_left = 0;
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 200;
    end
    if (hold_left != 0) begin
      hold_left--;
      evt_if.ready <= 1'b0;
    end else begin
      evt_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Event checker: every transfer on the event channel is matched against
  // the oldest outstanding prediction.
  always @(posedge clk_i) begin
    mouse_event_t want;
    if (rst_ni && evt_if.valid && evt_if.ready) begin
      if (pending_events.size() == 0) begin
        $error("event with nothing outstanding: kind %0d code %0d value %0d",
               evt_if.event_kind, evt_if.event_code, evt_if.event_value);
        fail_count++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_time", want.stamp, evt_if.event_time);
        check_field("event_kind", 64'(want.kind), 64'(evt_if.event_kind));
        check_field("event_code", 64'(want.code), 64'(evt_if.event_code));
        check_field("event_value", 64'($unsigned(want.value)),
                    64'($unsigned(evt_if.event_value)));
        check_field("last_event", 64'(want.last), 64'(evt_if.last_event));
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned drain_cycles;
    logic [2:0]  limit;
    pkt_if.valid       = 1'b0;
    pkt_if.status_byte = 8'h00;
    pkt_if.x_byte      = 8'h00;
    pkt_if.y_byte      = 8'h00;
    pkt_if.stamp_in    = 64'd0;
    evt_if.ready       = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = 3'd0;
    // First regime: the sender idles a third of the time, the receiver most.
    send_idle_pct  = 35;
    recv_stall_pct = 78;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].limit != model_limit) write_limit(directed_rows[i].limit);
      send_packet(directed_rows[i].pkt, directed_rows[i].typed, directed_rows[i].has_ev,
                  directed_rows[i].ev);
    end

    // Random part in eight blocks, each with its own limit. The regimes swap
    // after three blocks and idling stops for the last two.
    for (int blk = 0; blk < 8; blk++) begin
      if (blk == 3) begin
        send_idle_pct  = 78;
        recv_stall_pct = 35;
      end else if (blk == 6) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      limit = ($urandom_range(9) < 5) ? mpem_pkg::LIMIT_RESET : 3'($urandom_range(7));
      write_limit(limit);
      // With the sender running flat out, a long receiver hold fills the
      // block and must push back on the packet channel.
      if (blk == 6) hold_request = 1'b1;
      repeat (49) send_packet(random_packet(), 1'b0, 1'b0, '0);
    end

    pkt_if.valid <= 1'b0;
    drain_cycles = 0;
    while (pending_events.size() != 0 && drain_cycles < 5000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (10) @(posedge clk_i);
    if (pending_events.size() != 0) begin
      $error("%0d predicted events never arrived", pending_events.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/mpem_pkg.sv
rtl/core/mpem_pkt_if.sv
rtl/core/mpem_evt_if.sv
rtl/core/mpem_decode.sv
rtl/core/mpem_emit.sv
rtl/core/mouse_packet_event_mapper.sv
dv/tb_mouse_packet_event_mapper.sv
